FILE: rtl/ngp_mass_deposit_grid_assert.svh
// Assertion macros shared by the grid deposit RTL.
`ifndef NGP_MASS_DEPOSIT_GRID_ASSERT_SVH
`define NGP_MASS_DEPOSIT_GRID_ASSERT_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ngp_pkg.sv
package ngp_pkg;

    localparam int GRID_SIDE_DEF = 64;
    localparam int Q_DEPTH       = 4;

    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int SUM_W   = 48;
    localparam int IDX_W   = 12;
    localparam int FUNC_W  = 2;
    localparam int CFG_A_W = 2;
    localparam int OP_W    = 2;

    localparam logic [FUNC_W-1:0] FUNC_DEPOSIT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_CLEAR = 2'd2;

    localparam logic [CFG_A_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_INV_CELL = 2'd2;

    localparam logic [POS_W-1:0] INV_CELL_RESET = 32'h0001_0000;

    typedef enum logic [OP_W-1:0] {
        OP_DEPOSIT = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NULL    = 2'd3
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/ngp_front.sv
module ngp_front #(
    parameter int GRID_SIDE = ngp_pkg::GRID_SIDE_DEF,
    parameter int ADDR_W    = $clog2(GRID_SIDE * GRID_SIDE),
    parameter int ENT_W     = ngp_pkg::OP_W + ADDR_W + ngp_pkg::IDX_W + ngp_pkg::MASS_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ngp_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [ngp_pkg::POS_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ngp_pkg::FUNC_W-1:0]  i_func,
    input  logic [ngp_pkg::POS_W-1:0]   i_pos_x,
    input  logic [ngp_pkg::POS_W-1:0]   i_pos_y,
    input  logic [ngp_pkg::MASS_W-1:0]  i_body_mass,
    input  logic [ngp_pkg::IDX_W-1:0]   i_read_index,
    input  logic                        i_clear_done,
    input  ngp_pkg::t_q_stat            i_q_stat,
    output logic                        o_push,
    output logic [ENT_W-1:0]            o_q_data
);

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam int WIDE_W  = (ADDR_W > ngp_pkg::IDX_W) ? ADDR_W : ngp_pkg::IDX_W;
    localparam int PROD_W  = 2 * ngp_pkg::POS_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;

    logic [ngp_pkg::POS_W-1:0]  r_org_x, r_org_y, r_inv;
    logic [ngp_pkg::FUNC_W-1:0] r_func;
    logic [ngp_pkg::POS_W:0]    r_dx, r_dy;
    logic [ngp_pkg::MASS_W-1:0] r_mass;
    logic [ngp_pkg::IDX_W-1:0]  r_ridx;
    logic [PROD_W-1:0]          r_px, r_py;

    logic               accept;
    logic               inv_zero, x_in, y_in;
    logic [COORD_W-1:0] gx, gy;
    logic [ADDR_W-1:0]  dep_addr, rd_addr;
    logic [WIDE_W-1:0]  dep_wide, rd_wide;
    logic               rd_ok;
    ngp_pkg::t_op       op;
    logic [ADDR_W-1:0]  addr;
    logic [ngp_pkg::IDX_W-1:0] idx_out;

    assign o_ready = (r_state == F_IDLE) && i_clear_done;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_inv   <= ngp_pkg::INV_CELL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ngp_pkg::CFG_ORIGIN_X: r_org_x <= i_cfg_wdata;
                ngp_pkg::CFG_ORIGIN_Y: r_org_y <= i_cfg_wdata;
                ngp_pkg::CFG_INV_CELL: r_inv   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: if (!i_q_stat.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Offsets are exact in 33 bits; the products use the low 32 bits, which
    // hold the whole magnitude whenever the offset is not negative.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_dx   <= {i_pos_x[ngp_pkg::POS_W-1], i_pos_x} - {r_org_x[ngp_pkg::POS_W-1], r_org_x};
            r_dy   <= {i_pos_y[ngp_pkg::POS_W-1], i_pos_y} - {r_org_y[ngp_pkg::POS_W-1], r_org_y};
            r_mass <= i_body_mass;
            r_ridx <= i_read_index;
        end
        if (r_state == F_MUL) begin
            r_px <= PROD_W'(r_dx[ngp_pkg::POS_W-1:0]) * PROD_W'(r_inv);
            r_py <= PROD_W'(r_dy[ngp_pkg::POS_W-1:0]) * PROD_W'(r_inv);
        end
    end

    assign inv_zero = (r_inv == '0);
    assign x_in = inv_zero || (!r_dx[ngp_pkg::POS_W]
                  && (r_px[PROD_W-1:ngp_pkg::POS_W] < ngp_pkg::POS_W'(GRID_SIDE)));
    assign y_in = inv_zero || (!r_dy[ngp_pkg::POS_W]
                  && (r_py[PROD_W-1:ngp_pkg::POS_W] < ngp_pkg::POS_W'(GRID_SIDE)));
    assign gx = inv_zero ? '0 : r_px[ngp_pkg::POS_W +: COORD_W];
    assign gy = inv_zero ? '0 : r_py[ngp_pkg::POS_W +: COORD_W];

    assign dep_addr = ADDR_W'(gy) * ADDR_W'(GRID_SIDE) + ADDR_W'(gx);
    assign dep_wide = WIDE_W'(dep_addr);
    assign rd_wide  = WIDE_W'(r_ridx);
    assign rd_addr  = rd_wide[ADDR_W-1:0];
    assign rd_ok    = (32'(r_ridx) < 32'(CELLS));

    always_comb begin
        op      = ngp_pkg::OP_NULL;
        addr    = '0;
        idx_out = '0;
        unique case (r_func) inside
            ngp_pkg::FUNC_DEPOSIT: begin
                if (x_in && y_in) begin
                    op      = ngp_pkg::OP_DEPOSIT;
                    addr    = dep_addr;
                    idx_out = dep_wide[ngp_pkg::IDX_W-1:0];
                end
            end
            ngp_pkg::FUNC_READ, ngp_pkg::FUNC_READ_CLEAR: begin
                // An out-of-range read still reports its index.
                idx_out = r_ridx;
                if (rd_ok) begin
                    op   = (r_func == ngp_pkg::FUNC_READ) ? ngp_pkg::OP_READ
                                                          : ngp_pkg::OP_CLEAR;
                    addr = rd_addr;
                end
            end
            default: ;
        endcase
    end

    assign o_push   = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_q_data = {op, addr, idx_out, r_mass};

endmodule

FILE: rtl/ngp_fifo.sv
`include "ngp_mass_deposit_grid_assert.svh"

module ngp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ngp_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output ngp_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    `ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full || i_pop)
    `ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, !o_stat.empty)
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_stat.empty)

endmodule

FILE: rtl/ngp_back.sv
`include "ngp_mass_deposit_grid_assert.svh"

module ngp_back #(
    parameter int GRID_SIDE = ngp_pkg::GRID_SIDE_DEF,
    parameter int ADDR_W    = $clog2(GRID_SIDE * GRID_SIDE),
    parameter int ENT_W     = ngp_pkg::OP_W + ADDR_W + ngp_pkg::IDX_W + ngp_pkg::MASS_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ngp_pkg::t_q_stat           i_q_stat,
    input  logic [ENT_W-1:0]           i_q_data,
    output logic                       o_pop,
    output logic                       o_clear_done,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ngp_pkg::IDX_W-1:0]  o_cell_index,
    output logic [ngp_pkg::SUM_W-1:0]  o_cell_mass,
    output logic                       o_landed,
    output logic                       o_saturated
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int SUM_W = ngp_pkg::SUM_W;

    typedef enum logic [2:0] {
        B_CLR  = 3'b001,
        B_IDLE = 3'b010,
        B_EXEC = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    logic [SUM_W-1:0] r_mem [CELLS];
    logic [SUM_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;

    ngp_pkg::t_op               r_op;
    logic [ADDR_W-1:0]          r_addr;
    logic [ngp_pkg::IDX_W-1:0]  r_idx;
    logic [ngp_pkg::MASS_W-1:0] r_mass;

    logic                       r_o_valid, r_o_landed, r_o_sat;
    logic [ngp_pkg::IDX_W-1:0]  r_o_index;
    logic [SUM_W-1:0]           r_o_mass;

    ngp_pkg::t_op               q_op;
    logic [ADDR_W-1:0]          q_addr;
    logic [ngp_pkg::IDX_W-1:0]  q_idx;
    logic [ngp_pkg::MASS_W-1:0] q_mass;

    logic             slot_free, fire, clr_last;
    logic [SUM_W:0]   sum_wide;
    logic             sum_sat;
    logic [SUM_W-1:0] sum;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [SUM_W-1:0] mem_wdata;

    assign q_op   = ngp_pkg::t_op'(i_q_data[ENT_W-1 -: ngp_pkg::OP_W]);
    assign q_addr = i_q_data[ngp_pkg::IDX_W + ngp_pkg::MASS_W +: ADDR_W];
    assign q_idx  = i_q_data[ngp_pkg::MASS_W +: ngp_pkg::IDX_W];
    assign q_mass = i_q_data[ngp_pkg::MASS_W-1:0];

    assign slot_free    = !r_o_valid || i_ready;
    assign fire         = (r_state == B_EXEC) && slot_free;
    assign o_pop        = (r_state == B_IDLE) && !i_q_stat.empty;
    assign o_clear_done = (r_state != B_CLR);
    assign clr_last     = (r_clr_addr == ADDR_W'(CELLS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLR:  if (clr_last) n_state = B_IDLE;
            B_IDLE: if (o_pop) n_state = B_EXEC;
            B_EXEC: if (slot_free) n_state = B_IDLE;
            default: n_state = B_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == B_CLR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op   <= q_op;
            r_addr <= q_addr;
            r_idx  <= q_idx;
            r_mass <= q_mass;
        end
    end

    assign sum_wide = {1'b0, r_rdata} + (SUM_W + 1)'(r_mass);
    assign sum_sat  = sum_wide[SUM_W];
    assign sum      = sum_sat ? '1 : sum_wide[SUM_W-1:0];

    // The clearing pass owns the write port until it reaches the last cell.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        if (r_state == B_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (fire && r_op == ngp_pkg::OP_DEPOSIT) begin
            mem_we    = 1'b1;
            mem_wdata = sum;
        end else if (fire && r_op == ngp_pkg::OP_CLEAR) begin
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rdata <= r_mem[q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fire) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_index <= r_idx;
            case (r_op) inside
                ngp_pkg::OP_DEPOSIT: begin
                    r_o_mass   <= sum;
                    r_o_landed <= 1'b1;
                    r_o_sat    <= sum_sat;
                end
                ngp_pkg::OP_READ, ngp_pkg::OP_CLEAR: begin
                    r_o_mass   <= r_rdata;
                    r_o_landed <= 1'b1;
                    r_o_sat    <= 1'b0;
                end
                default: begin
                    r_o_mass   <= '0;
                    r_o_landed <= 1'b0;
                    r_o_sat    <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_cell_index = r_o_index;
    assign o_cell_mass  = r_o_mass;
    assign o_landed     = r_o_landed;
    assign o_saturated  = r_o_sat;

    `ASSERT_IMPLY(a_sat_lands, i_clk, i_rst_n, r_o_valid && r_o_sat, r_o_landed)
    `ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, r_o_valid && !r_o_landed, r_o_mass == '0)
    `ASSERT_IMPLY(a_clr_quiet, i_clk, i_rst_n, r_state == B_CLR, !r_o_valid && !o_pop)

endmodule

FILE: rtl/ngp_mass_deposit_grid.sv
// The front end takes a new item only once the last has passed capture, multiply
// and enqueue (enqueue waits while the queue is full); the back end reads, then
// executes each item on the single-port cell store, held while a result waits.
// Reset is synchronous and active low. After reset a clearing pass zeroes all
// GRID_SIDE * GRID_SIDE cells, one per cycle (4096 cells at the default size),
// with o_ready low; configuration writes are taken throughout.
module ngp_mass_deposit_grid #(
    parameter int GRID_SIDE = ngp_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ngp_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [ngp_pkg::POS_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ngp_pkg::FUNC_W-1:0]  i_func,
    input  logic [ngp_pkg::POS_W-1:0]   i_pos_x,
    input  logic [ngp_pkg::POS_W-1:0]   i_pos_y,
    input  logic [ngp_pkg::MASS_W-1:0]  i_body_mass,
    input  logic [ngp_pkg::IDX_W-1:0]   i_read_index,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ngp_pkg::IDX_W-1:0]   o_cell_index,
    output logic [ngp_pkg::SUM_W-1:0]   o_cell_mass,
    output logic                        o_landed,
    output logic                        o_saturated
);

    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int ENT_W  = ngp_pkg::OP_W + ADDR_W + ngp_pkg::IDX_W + ngp_pkg::MASS_W;

    ngp_pkg::t_q_stat q_stat;
    logic             push, pop, clear_done;
    logic [ENT_W-1:0] push_data, head_data;

    ngp_front #(
        .GRID_SIDE (GRID_SIDE),
        .ADDR_W    (ADDR_W),
        .ENT_W     (ENT_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_body_mass  (i_body_mass),
        .i_read_index (i_read_index),
        .i_clear_done (clear_done),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_q_data     (push_data)
    );

    ngp_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (ngp_pkg::Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_stat  (q_stat)
    );

    ngp_back #(
        .GRID_SIDE (GRID_SIDE),
        .ADDR_W    (ADDR_W),
        .ENT_W     (ENT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_q_data     (head_data),
        .o_pop        (pop),
        .o_clear_done (clear_done),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cell_index (o_cell_index),
        .o_cell_mass  (o_cell_mass),
        .o_landed     (o_landed),
        .o_saturated  (o_saturated)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int GRID_SIDE      = ngp_pkg::GRID_SIDE_DEF;
    localparam int CELLS          = GRID_SIDE * GRID_SIDE;
    localparam int COORD_W        = $clog2(GRID_SIDE);
    localparam int TAIL_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT = 4 * CELLS + 2000;
    localparam logic [ngp_pkg::SUM_W:0]   MASS_MAX = {1'b0, {ngp_pkg::SUM_W{1'b1}}};
    localparam logic [ngp_pkg::POS_W-1:0] Q_ONE    = 32'h0001_0000;

    typedef struct packed {
        logic [ngp_pkg::IDX_W-1:0] index;
        logic [ngp_pkg::SUM_W-1:0] mass;
        logic                      landed;
        logic                      saturated;
    } t_cell_result;

    typedef struct packed {
        ngp_pkg::t_op               op;
        logic [ngp_pkg::POS_W-1:0]  pos_x;
        logic [ngp_pkg::POS_W-1:0]  pos_y;
        logic [ngp_pkg::MASS_W-1:0] mass;
        logic [ngp_pkg::IDX_W-1:0]  read_index;
        logic                       fixed;
        t_cell_result               want;
    } t_stim_row;

    // Rows with fixed set carry a result that is known by inspection; the others
    // are checked against the grid predictor.
    localparam t_stim_row DIRECTED_ROWS [0:16] = '{
        '{ngp_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 12'd0, 1'b1,
          '{12'd0, 48'd0, 1'b1, 1'b0}},
        '{ngp_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 12'd4095, 1'b1,
          '{12'd4095, 48'd0, 1'b1, 1'b0}},
        '{ngp_pkg::OP_DEPOSIT, 32'h0, 32'h0, 32'hFFFF_FFFF, 12'd0, 1'b1,
          '{12'd0, 48'h0000_FFFF_FFFF, 1'b1, 1'b0}},
        '{ngp_pkg::OP_DEPOSIT, 32'h003F_FFFF, 32'h003F_FFFF, 32'h1, 12'd0, 1'b1,
          '{12'd4095, 48'd1, 1'b1, 1'b0}},
        '{ngp_pkg::OP_DEPOSIT, 32'h0040_0000, 32'h0, 32'h5, 12'd0, 1'b1, '0},
        '{ngp_pkg::OP_DEPOSIT, 32'h0, 32'h8000_0000, 32'h5, 12'd0, 1'b1, '0},
        '{ngp_pkg::OP_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 12'd0, 1'b1, '0},
        '{ngp_pkg::OP_NULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd4095, 1'b1, '0},
        '{ngp_pkg::OP_DEPOSIT, 32'h0002_8000, Q_ONE, 32'h0, 12'd0, 1'b1,
          '{12'd66, 48'd0, 1'b1, 1'b0}},
        '{ngp_pkg::OP_DEPOSIT, 32'h0, 32'h0, 32'h1234_5678, 12'd0, 1'b0, '0},
        '{ngp_pkg::OP_DEPOSIT, 32'hFFFF_FFFF, 32'h0, 32'h7, 12'd0, 1'b1, '0},
        '{ngp_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 12'd0, 1'b0, '0},
        '{ngp_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 12'd0, 1'b0, '0},
        '{ngp_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 12'd0, 1'b1,
          '{12'd0, 48'd0, 1'b1, 1'b0}},
        '{ngp_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 12'd4095, 1'b1,
          '{12'd4095, 48'd1, 1'b1, 1'b0}},
        '{ngp_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 12'd66, 1'b0, '0},
        '{ngp_pkg::OP_DEPOSIT, 32'h0010_8000, 32'h0020_0000, 32'h0003_0000, 12'd0, 1'b1,
          '{12'd2064, 48'h3_0000, 1'b1, 1'b0}}
    };

    logic                        i_clk;
    logic                        i_rst_n      = 1'b0;
    logic                        i_cfg_we     = 1'b0;
    logic [ngp_pkg::CFG_A_W-1:0] i_cfg_addr   = ngp_pkg::CFG_ORIGIN_X;
    logic [ngp_pkg::POS_W-1:0]   i_cfg_wdata  = '0;
    logic                        i_valid      = 1'b0;
    logic                        o_ready;
    logic [ngp_pkg::FUNC_W-1:0]  i_func       = ngp_pkg::OP_NULL;
    logic [ngp_pkg::POS_W-1:0]   i_pos_x      = '0;
    logic [ngp_pkg::POS_W-1:0]   i_pos_y      = '0;
    logic [ngp_pkg::MASS_W-1:0]  i_body_mass  = '0;
    logic [ngp_pkg::IDX_W-1:0]   i_read_index = '0;
    logic                        o_valid;
    logic                        i_ready      = 1'b0;
    logic [ngp_pkg::IDX_W-1:0]   o_cell_index;
    logic [ngp_pkg::SUM_W-1:0]   o_cell_mass;
    logic                        o_landed;
    logic                        o_saturated;

    // Fixed expectation that travels with the current input transaction.
    logic         row_fixed  = 1'b0;
    t_cell_result row_expect = '0;

    logic [ngp_pkg::SUM_W-1:0] cell_sums [CELLS];
    logic [ngp_pkg::POS_W-1:0] origin_x_cfg;
    logic [ngp_pkg::POS_W-1:0] origin_y_cfg;
    logic [ngp_pkg::POS_W-1:0] inv_cell_cfg;
    t_cell_result              expected_cells [$];
    logic [ngp_pkg::IDX_W-1:0] recent_cells [$];

    logic [ngp_pkg::POS_W-1:0] aim_org_x;
    logic [ngp_pkg::POS_W-1:0] aim_org_y;
    logic [63:0]               aim_span;
    int               gap_pct       = 0;
    int               stall_pct     = 0;
    int               stall_left    = 0;
    int               mismatch_count = 0;
    int               idle_cycles   = 0;

    ngp_mass_deposit_grid #(
        .GRID_SIDE(GRID_SIDE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_body_mass (i_body_mass),
        .i_read_index(i_read_index),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cell_index(o_cell_index),
        .o_cell_mass (o_cell_mass),
        .o_landed    (o_landed),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floored cell coordinate on one axis; returns 0 when the body is off the grid.
    function automatic logic axis_cell(input logic [ngp_pkg::POS_W-1:0] pos,
                                       input logic [ngp_pkg::POS_W-1:0] org,
                                       output logic [COORD_W-1:0] coord);
        logic signed [ngp_pkg::POS_W:0] offset;
        logic [63:0]                    scaled;
        offset = $signed({pos[ngp_pkg::POS_W-1], pos}) - $signed({org[ngp_pkg::POS_W-1], org});
        coord  = '0;
        if (inv_cell_cfg == '0) begin
            return 1'b1;
        end
        if (offset < 0) begin
            return 1'b0;
        end
        scaled = {32'b0, offset[ngp_pkg::POS_W-1:0]} * {32'b0, inv_cell_cfg};
        if (scaled[63:32] >= GRID_SIDE) begin
            return 1'b0;
        end
        coord = scaled[32 +: COORD_W];
        return 1'b1;
    endfunction

    function automatic t_cell_result apply_grid_op(input ngp_pkg::t_op op,
                                                   input logic [ngp_pkg::POS_W-1:0] px,
                                                   input logic [ngp_pkg::POS_W-1:0] py,
                                                   input logic [ngp_pkg::MASS_W-1:0] mass,
                                                   input logic [ngp_pkg::IDX_W-1:0] ridx);
        t_cell_result              res;
        logic [COORD_W-1:0]        gx;
        logic [COORD_W-1:0]        gy;
        logic [ngp_pkg::SUM_W:0]   total;
        int unsigned               cell_id;
        res = '0;
        case (op) inside
            ngp_pkg::OP_DEPOSIT: begin
                if (axis_cell(px, origin_x_cfg, gx) && axis_cell(py, origin_y_cfg, gy)) begin
                    cell_id = gy * GRID_SIDE + gx;
                    total   = {1'b0, cell_sums[cell_id]}
                              + {{(ngp_pkg::SUM_W + 1 - ngp_pkg::MASS_W){1'b0}}, mass};
                    if (total > MASS_MAX) begin
                        total = MASS_MAX;
                        res.saturated = 1'b1;
                    end
                    cell_sums[cell_id] = total[ngp_pkg::SUM_W-1:0];
                    res.index  = cell_id[ngp_pkg::IDX_W-1:0];
                    res.mass   = total[ngp_pkg::SUM_W-1:0];
                    res.landed = 1'b1;
                end
            end
            ngp_pkg::OP_READ, ngp_pkg::OP_CLEAR: begin
                res.index = ridx;
                if (ridx < CELLS) begin
                    res.mass   = cell_sums[ridx];
                    res.landed = 1'b1;
                    if (op == ngp_pkg::OP_CLEAR) begin
                        cell_sums[ridx] = '0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        // Keep the log readable if a bug repeats over many transactions.
        if (mismatch_count < 50) begin
            $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime,
                     got_v, want_v);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : grid_check
        t_cell_result calc;
        t_cell_result got;
        t_cell_result want;
        if (!i_rst_n) begin
            foreach (cell_sums[n]) cell_sums[n] = '0;
            origin_x_cfg = '0;
            origin_y_cfg = '0;
            inv_cell_cfg = ngp_pkg::INV_CELL_RESET;
            expected_cells.delete();
            recent_cells.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ngp_pkg::CFG_ORIGIN_X: origin_x_cfg = i_cfg_wdata;
                    ngp_pkg::CFG_ORIGIN_Y: origin_y_cfg = i_cfg_wdata;
                    ngp_pkg::CFG_INV_CELL: inv_cell_cfg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                calc = apply_grid_op(ngp_pkg::t_op'(i_func), i_pos_x, i_pos_y, i_body_mass,
                                     i_read_index);
                if (calc.landed && ngp_pkg::t_op'(i_func) == ngp_pkg::OP_DEPOSIT) begin
                    recent_cells.push_back(calc.index);
                    if (recent_cells.size() > 16) begin
                        void'(recent_cells.pop_front());
                    end
                end
                expected_cells.push_back(row_fixed ? row_expect : calc);
            end
            if (o_valid && i_ready) begin
                got = {o_cell_index, o_cell_mass, o_landed, o_saturated};
                if (expected_cells.size() == 0) begin
                    report_mismatch("result with nothing pending", got.mass, '0);
                end else begin
                    want = expected_cells.pop_front();
                    if (got.index != want.index) begin
                        report_mismatch("cell_index", got.index, want.index);
                    end
                    if (got.mass != want.mass) begin
                        report_mismatch("cell_mass", got.mass, want.mass);
                    end
                    if (got.landed != want.landed) begin
                        report_mismatch("landed", got.landed, want.landed);
                    end
                    if (got.saturated != want.saturated) begin
                        report_mismatch("saturated", got.saturated, want.saturated);
                    end
                end
            end
        end
    end

    // Result side back-pressure in bursts of random length.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(0, 7);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // The clearing pass after reset holds o_ready low while it zeroes all CELLS
    // cells, so the limit sits well above the length of that pass.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(input ngp_pkg::t_op op, input logic [ngp_pkg::POS_W-1:0] px,
                           input logic [ngp_pkg::POS_W-1:0] py,
                           input logic [ngp_pkg::MASS_W-1:0] mass,
                           input logic [ngp_pkg::IDX_W-1:0] ridx, input logic fixed,
                           input t_cell_result want);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= op;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_body_mass  <= mass;
        i_read_index <= ridx;
        row_fixed    <= fixed;
        row_expect   <= want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_cells.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [ngp_pkg::POS_W-1:0] org_x,
                               input logic [ngp_pkg::POS_W-1:0] org_y,
                               input logic [ngp_pkg::POS_W-1:0] inv_cell);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= ngp_pkg::CFG_ORIGIN_X;
        i_cfg_wdata <= org_x;
        @(posedge i_clk);
        i_cfg_addr  <= ngp_pkg::CFG_ORIGIN_Y;
        i_cfg_wdata <= org_y;
        @(posedge i_clk);
        i_cfg_addr  <= ngp_pkg::CFG_INV_CELL;
        i_cfg_wdata <= inv_cell;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        aim_org_x = org_x;
        aim_org_y = org_y;
        // Largest offset that still floors to a coordinate inside the grid.
        if (inv_cell == '0) begin
            aim_span = 64'hFFFF_FFFF;
        end else begin
            aim_span = ((64'd1 << (32 + COORD_W)) - 1) / inv_cell;
            if (aim_span > 64'hFFFF_FFFF) begin
                aim_span = 64'hFFFF_FFFF;
            end
        end
    endtask

    function automatic logic [ngp_pkg::POS_W-1:0] aim_position(
        input logic [ngp_pkg::POS_W-1:0] org);
        logic [63:0] offset;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20) begin
            return $urandom();
        end
        offset = {$urandom(), $urandom()} % (aim_span + 1);
        if (pick < 32) begin
            offset = aim_span + $urandom_range(0, 4) - 2;
        end
        return org + offset[ngp_pkg::POS_W-1:0];
    endfunction

    task automatic send_random_op();
        ngp_pkg::t_op               op;
        logic [ngp_pkg::MASS_W-1:0] mass;
        logic [ngp_pkg::IDX_W-1:0]  ridx;
        int unsigned                pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            op = ngp_pkg::OP_DEPOSIT;
        end else if (pick < 78) begin
            op = ngp_pkg::OP_READ;
        end else if (pick < 95) begin
            op = ngp_pkg::OP_CLEAR;
        end else begin
            op = ngp_pkg::OP_NULL;
        end
        pick = $urandom_range(99);
        if (pick < 15) begin
            mass = 32'hFFFF_FFFF;
        end else if (pick < 30) begin
            mass = $urandom_range(0, 255);
        end else begin
            mass = $urandom();
        end
        if (recent_cells.size() != 0 && $urandom_range(1) == 1) begin
            ridx = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
        end else begin
            ridx = $urandom_range(0, CELLS - 1);
        end
        send_op(op, aim_position(aim_org_x), aim_position(aim_org_y), mass, ridx, 1'b0, '0);
    endtask

    task automatic run_phase(input logic [ngp_pkg::POS_W-1:0] org_x,
                             input logic [ngp_pkg::POS_W-1:0] org_y,
                             input logic [ngp_pkg::POS_W-1:0] inv_cell, input int count,
                             input int gap, input int stall);
        drain_results();
        load_config(org_x, org_y, inv_cell);
        gap_pct = gap;
        stall_pct <= stall;
        repeat (count) send_random_op();
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct = 15;
        stall_pct <= 15;
        foreach (DIRECTED_ROWS[n]) begin
            send_op(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].pos_x, DIRECTED_ROWS[n].pos_y,
                    DIRECTED_ROWS[n].mass, DIRECTED_ROWS[n].read_index,
                    DIRECTED_ROWS[n].fixed, DIRECTED_ROWS[n].want);
        end

        run_phase('0, '0, ngp_pkg::INV_CELL_RESET, 120, 15, 15);
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 70, 35, 0);
        // With a zero reciprocal every body lands in cell 0.
        run_phase($urandom(), $urandom(), '0, 63, 0, 35);
        run_phase($urandom(), $urandom(), $urandom_range(32'h1000, 32'h10_0000), 120, 10, 10);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 50, 35, 35);
        run_phase($urandom(), $urandom(), $urandom(), 100, 15, 35);
        // The closing stretch runs at full rate on both sides.
        run_phase('0, '0, ngp_pkg::INV_CELL_RESET, 110, 0, 0);
        drain_results();

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ngp_pkg.sv
rtl/ngp_front.sv
rtl/ngp_fifo.sv
rtl/ngp_back.sv
rtl/ngp_mass_deposit_grid.sv
tb/testbench.sv
